// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the receiver pairing filter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define RPF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rpf assertion failed");

// expression must never be true out of reset
`define RPF_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("rpf forbidden condition seen");

`else

`define RPF_ASSERT(lbl, clk, rst_n, prop)
`define RPF_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== design/rpf_pkg.sv =====
// ----------------------------------------------------------------------------
// rpf_pkg
// Beat types, register indexes, codes and reset values of the pairing filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rpf_pkg;

  // operation codes
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // verdict codes
  localparam logic [1:0] VERDICT_REJECT = 2'd0;
  localparam logic [1:0] VERDICT_KNOWN  = 2'd1;
  localparam logic [1:0] VERDICT_LEARN  = 2'd2;
  localparam logic [1:0] VERDICT_TICK   = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIR_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_MASK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAMP_MASK   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAMP_HOLD   = 2'd3;
  localparam int unsigned CFG_DATA_W = 16;

  // register reset values
  localparam logic [15:0] PAIR_WINDOW_RST = 16'd3000;
  localparam logic [7:0]  LEARN_MASK_RST  = 8'd8;
  localparam logic [7:0]  LAMP_MASK_RST   = 8'd15;
  localparam logic [15:0] LAMP_HOLD_RST   = 16'd60;

  // link quality bit that marks good reception
  localparam int unsigned LQ_GOOD_BIT = 7;

  localparam logic [15:0] HOLD_MAX = 16'hFFFF;

  typedef struct packed {
    logic        operation;
    logic [7:0]  link_quality;
    logic [31:0] source_address;
    logic [7:0]  command_first;
    logic [7:0]  command_second;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [7:0] lamp_outputs;
    logic       paired;
    logic       store_request;
    logic       erase_first;
    logic [6:0] store_slot;
  } out_beat_t;

  // configuration register set
  typedef struct packed {
    logic [15:0] pair_window_ticks;
    logic [7:0]  learn_signal_mask;
    logic [7:0]  lamp_mask;
    logic [15:0] lamp_hold_ticks;
  } cfg_t;

endpackage

`default_nettype wire

// ===== design/rpf_in_stage.sv =====
// ----------------------------------------------------------------------------
// rpf_in_stage
// Input register: holds one beat until the decision logic consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rpf_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire rpf_pkg::in_beat_t in_data,
  output logic                   in_stall,
  input  wire logic              adv,
  output logic                   item_vld,
  output rpf_pkg::in_beat_t      item
);

  logic              vld_r, vld_nxt;
  rpf_pkg::in_beat_t data_r;
  logic              take;

  // stall only while a held beat is not moving on
  assign in_stall = vld_r && !adv;
  assign take     = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_data;
    end
  end

  assign item_vld = vld_r;
  assign item     = data_r;

endmodule

`default_nettype wire

// ===== design/rpf_core.sv =====
// ----------------------------------------------------------------------------
// rpf_core
// Per-beat decision logic with the pairing, lamp and slot state registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rpf_core #(
  parameter int unsigned SLOT_COUNT = 128
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire rpf_pkg::in_beat_t item,
  input  wire rpf_pkg::cfg_t     cfg,
  output rpf_pkg::out_beat_t     result
);

  localparam int unsigned SLOT_CMP_W = 9;
  localparam logic [SLOT_CMP_W-1:0] SLOT_LIMIT = SLOT_CMP_W'(SLOT_COUNT);

  logic [31:0] learned_r, learned_nxt;
  logic        paired_r, paired_nxt;
  logic [15:0] window_r, window_nxt;
  logic [7:0]  lamp_r, lamp_nxt;
  logic [15:0] hold_r, hold_nxt;
  logic [7:0]  slot_cnt_r, slot_cnt_nxt;

  logic       pkt_good;
  logic       addr_known;
  logic       can_learn;
  logic [7:0] slot;
  logic [7:0] lamp_drive;
  logic [7:0] lamp_mid;

  assign pkt_good   = item.link_quality[rpf_pkg::LQ_GOOD_BIT] &&
                      (item.command_first == item.command_second);
  assign addr_known = (item.source_address == learned_r);
  assign can_learn  = !paired_r && (window_r != 16'd0) &&
                      ((item.command_second & cfg.learn_signal_mask) != 8'd0);
  // wrap to slot 0 once the count runs past the slot store
  assign slot       = ({1'b0, slot_cnt_r} >= SLOT_LIMIT) ? 8'd0 : slot_cnt_r;
  assign lamp_drive = (lamp_r & ~cfg.lamp_mask) | item.command_first;

  // decision
  always_comb begin
    learned_nxt  = learned_r;
    paired_nxt   = paired_r;
    window_nxt   = window_r;
    lamp_mid     = lamp_r;
    hold_nxt     = hold_r;
    slot_cnt_nxt = slot_cnt_r;
    result       = '0;
    priority if (item.operation == rpf_pkg::OP_TICK) begin
      result.verdict = rpf_pkg::VERDICT_TICK;
      if (hold_r != rpf_pkg::HOLD_MAX) begin
        hold_nxt = hold_r + 16'd1;
      end
      if (!paired_r && (window_r != 16'd0)) begin
        window_nxt = window_r - 16'd1;
      end
    end else if (!pkt_good) begin
      result.verdict = rpf_pkg::VERDICT_REJECT;
    end else if (addr_known) begin
      result.verdict = rpf_pkg::VERDICT_KNOWN;
      paired_nxt     = 1'b1;
      lamp_mid       = lamp_drive;
      hold_nxt       = 16'd0;
    end else if (can_learn) begin
      result.verdict       = rpf_pkg::VERDICT_LEARN;
      result.store_request = 1'b1;
      result.erase_first   = (slot == 8'd0);
      result.store_slot    = slot[6:0];
      learned_nxt          = item.source_address;
      paired_nxt           = 1'b1;
      slot_cnt_nxt         = slot + 8'd1;
      lamp_mid             = lamp_drive;
      hold_nxt             = 16'd0;
    end else begin
      result.verdict = rpf_pkg::VERDICT_REJECT;
    end
    // hold expiry after every beat
    lamp_nxt = (hold_nxt > cfg.lamp_hold_ticks) ? (lamp_mid & ~cfg.lamp_mask) : lamp_mid;
    result.lamp_outputs = lamp_nxt;
    result.paired       = paired_nxt;
  end

  // state update on each consumed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learned_r  <= 32'd0;
      paired_r   <= 1'b0;
      window_r   <= rpf_pkg::PAIR_WINDOW_RST;
      lamp_r     <= 8'd0;
      hold_r     <= 16'd0;
      slot_cnt_r <= 8'd0;
    end else if (adv) begin
      learned_r  <= learned_nxt;
      paired_r   <= paired_nxt;
      window_r   <= window_nxt;
      lamp_r     <= lamp_nxt;
      hold_r     <= hold_nxt;
      slot_cnt_r <= slot_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/receiver_pairing_filter.sv =====
// ----------------------------------------------------------------------------
// receiver_pairing_filter
// Packet/tick filter that learns one transmitter and drives held lamp bits.
// ----------------------------------------------------------------------------
//   channel  | direction | ports                          | beat
//   ---------+-----------+--------------------------------+-------------------
//   input    | in        | in_valid, in_stall, in_data    | packet or tick
//   result   | out       | out_valid, out_stall, out_data | one per input beat
//   config   | in        | cfg_we, cfg_index, cfg_wdata   | register write
//
// One beat per cycle sustained while out_stall is low; an accepted beat passes
// from the input register through the decision logic into the result register.
// Reset (rst_n low, synchronous) loads register defaults and clears state;
// the pairing window restarts from its default of 3000 ticks.
// out_stall backs up through the result register into in_stall in the same
// cycle, so no beat is dropped while the result side waits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module receiver_pairing_filter #(
  parameter int unsigned SLOT_COUNT = 128
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire rpf_pkg::in_beat_t                  in_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output rpf_pkg::out_beat_t                      out_data,
  input  wire logic                               cfg_we,
  input  wire logic [rpf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rpf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  rpf_pkg::cfg_t      cfg_r, cfg_nxt;
  rpf_pkg::in_beat_t  item;
  rpf_pkg::out_beat_t result;
  rpf_pkg::out_beat_t out_r;
  logic               item_vld;
  logic               adv;
  logic               out_vld_r, out_vld_nxt;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        rpf_pkg::CFG_PAIR_WINDOW: cfg_nxt.pair_window_ticks = cfg_wdata;
        rpf_pkg::CFG_LEARN_MASK:  cfg_nxt.learn_signal_mask = cfg_wdata[7:0];
        rpf_pkg::CFG_LAMP_MASK:   cfg_nxt.lamp_mask         = cfg_wdata[7:0];
        rpf_pkg::CFG_LAMP_HOLD:   cfg_nxt.lamp_hold_ticks   = cfg_wdata;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pair_window_ticks <= rpf_pkg::PAIR_WINDOW_RST;
      cfg_r.learn_signal_mask <= rpf_pkg::LEARN_MASK_RST;
      cfg_r.lamp_mask         <= rpf_pkg::LAMP_MASK_RST;
      cfg_r.lamp_hold_ticks   <= rpf_pkg::LAMP_HOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // a held beat moves on when the result register is free or draining
  assign adv = item_vld && (!out_vld_r || !out_stall);

  rpf_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .adv      (adv),
    .item_vld (item_vld),
    .item     (item)
  );

  rpf_core #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .item   (item),
    .cfg    (cfg_r),
    .result (result)
  );

  // result register
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // checks
  `RPF_ASSERT(a_store_only_on_learn, clk, rst_n, (out_vld_r && out_r.store_request) |-> (out_r.verdict == rpf_pkg::VERDICT_LEARN))
  `RPF_ASSERT(a_erase_at_slot0, clk, rst_n, (out_vld_r && out_r.erase_first) |-> (out_r.store_request && (out_r.store_slot == 7'd0)))
  `RPF_ASSERT_NEVER(a_stall_when_empty, clk, rst_n, in_stall && !item_vld)
  `RPF_ASSERT(a_learn_is_paired, clk, rst_n, (out_vld_r && (out_r.verdict == rpf_pkg::VERDICT_LEARN)) |-> out_r.paired)

endmodule

`default_nettype wire
